### design/mtf_pkg.sv
package mtf_pkg;

   // Number of cells in the row (list capacity).
   localparam int CAPACITY = 16;

   // Cell index width and occupancy counter width follow from the capacity.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response.
   localparam int MODE_W = 2;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_FIND = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Broadcast from the top level to every cell in the row.
   typedef struct packed {
      logic fire;
      mode_type mode;
      logic [VALUE_W-1:0] value;
      logic full;
      logic any_hit;
      logic [CNT_W-1:0] occupancy;
   } cell_ctl_type;

endpackage

### design/mtf_req_if.sv
interface mtf_req_if
   import mtf_pkg::*;
();
   logic valid;
   logic ready;
   logic [MODE_W-1:0] mode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

### design/mtf_rsp_if.sv
interface mtf_rsp_if
   import mtf_pkg::*;
();
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0] match_position;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output match_position, output entry_count,
                   input ready);
   modport sink (input valid, input status, input match_position, input entry_count,
                 output ready);
endinterface

### design/mtf_cell.sv
module mtf_cell
   import mtf_pkg::*;
(
   input  logic               clock,
   input  logic [IDX_W-1:0]   cell_index,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] left_entry,
   input  logic [VALUE_W-1:0] right_entry,
   input  logic               before_in,
   output logic               before_out,
   output logic [VALUE_W-1:0] entry_out,
   output logic [IDX_W-1:0]   first_pos
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               cell_valid;
   logic               hit;

   assign cell_valid = CNT_W'(cell_index) < ctl.occupancy;
   assign hit = cell_valid && (entry_ff == ctl.value);
   assign before_out = before_in | hit;
   assign first_pos = (hit && !before_in) ? cell_index : '0;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.fire) begin
         case (ctl.mode)
            MODE_INSERT: begin
               if (!ctl.full) entry_in = left_entry;
            end
            MODE_DELETE: begin
               // at or behind the first match: close the gap
               if (before_in || hit) entry_in = right_entry;
            end
            MODE_FIND: begin
               // at or ahead of the match: rotate towards the back
               if (ctl.any_hit && !before_in) entry_in = left_entry;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### design/move_to_front_list.sv
// Move-to-front list of up to CAPACITY signed 32-bit values, front first.
// Each request carries a mode (insert at front, delete first match, find and
// move to front, clear) and a value; each gives one response with a status,
// the position of the first match before any move, and the new entry count.
// The list lives in a row of identical cells, one entry each; every cell
// compares its entry with the request value and loads from its left or right
// neighbour, so the whole search-and-shift is combinational up to the entry
// registers. A request is taken every cycle unless a response waits unread;
// its response appears in the output register on the following cycle, and a
// new request is taken while that response waits only if it is being read in
// the same cycle. The compare and first-match chain runs across the row of
// cells. Duplicates are kept; an insert into a full list is dropped with
// status full. No clearing pass is needed after reset.
module move_to_front_list
   import mtf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mtf_req_if.sink   req_chan,
   mtf_rsp_if.source rsp_chan
);

   // request handshake
   logic         fire;
   mode_type     req_mode;
   cell_ctl_type ctl;

   // occupancy and response registers
   logic [CNT_W-1:0]   occupancy_ff, occupancy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   // cell row links
   logic [VALUE_W-1:0] cell_entry [CAPACITY];
   logic               cell_before [CAPACITY+1];
   logic [IDX_W-1:0]   cell_pos [CAPACITY];
   logic [IDX_W-1:0]   match_idx;
   logic               list_full;
   logic               any_hit;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire = req_chan.valid && req_chan.ready;
   assign req_mode = mode_type'(req_chan.mode);

   assign list_full = (occupancy_ff >= CNT_W'(CAPACITY));
   assign any_hit = cell_before[CAPACITY];

   always_comb begin
      ctl.fire = fire;
      ctl.mode = req_mode;
      ctl.value = req_chan.value;
      ctl.full = list_full;
      ctl.any_hit = any_hit;
      ctl.occupancy = occupancy_ff;
   end

   // the first-match flag ripples from the front of the row
   assign cell_before[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_entry;
      logic [VALUE_W-1:0] right_entry;

      if (i == 0) begin : g_front
         assign left_entry = req_chan.value;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      mtf_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .before_in   (cell_before[i]),
         .before_out  (cell_before[i+1]),
         .entry_out   (cell_entry[i]),
         .first_pos   (cell_pos[i])
      );
   end

   // at most one cell reports a non-zero first-match position
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_idx = match_idx | cell_pos[i];
      end
   end

   always_comb begin
      occupancy_in = occupancy_ff;
      status_in = STATUS_DONE;
      pos_in = '0;
      case (req_mode)
         MODE_INSERT: begin
            if (list_full) begin
               status_in = STATUS_FULL;
            end else begin
               occupancy_in = occupancy_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (any_hit) begin
               pos_in = POS_W'(match_idx);
               occupancy_in = occupancy_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         MODE_FIND: begin
            if (any_hit) begin
               pos_in = POS_W'(match_idx);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         default: occupancy_in = '0;
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            occupancy_ff <= occupancy_in;
         end
      end
   end

   // response payload: loaded on each accepted request
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         pos_ff <= pos_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.match_position = pos_ff;
   assign rsp_chan.entry_count = COUNT_W'(occupancy_ff);

   // occupancy never runs past the number of cells
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   // a clear empties the list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && req_mode == MODE_CLEAR |=> occupancy_ff == '0)
      else $error("clear left entries behind");

   // a full report only ever comes with a full list
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_FULL |-> occupancy_ff == CNT_W'(CAPACITY))
      else $error("full status with room left");

   // a successful insert grows the list by one
   a_insert: assert property (@(posedge clock) disable iff (reset)
      fire && req_mode == MODE_INSERT && !list_full
      |=> occupancy_ff == $past(occupancy_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

endmodule
